// ===== hw/rtl/positional_record_list_assert.svh =====
// assertion helpers for the rtl
`ifndef POSITIONAL_RECORD_LIST_ASSERT_SVH
`define POSITIONAL_RECORD_LIST_ASSERT_SVH

// condition that holds at every edge out of reset
`define PRL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence in the same cycle as the trigger
`define PRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the trigger
`define PRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/prl_pkg.sv =====
package prl_pkg;

   // list depth and derived widths
   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // field widths
   localparam int NAME_W   = 64;
   localparam int NUMBER_W = 56;
   localparam int AGE_W    = 8;
   localparam int SCORE_W  = 64;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 3;

   // one stored record, name in the low bits
   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [AGE_W-1:0]    age;
      logic [NUMBER_W-1:0] number;
      logic [NAME_W-1:0]   name;
   } record_type;

   localparam int REC_W      = $bits(record_type);
   localparam int REQ_DATA_W = ((POS_W + REC_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * POS_W + REC_W + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_DELETE = 3'd2,
      ACT_FIND   = 3'd3,
      ACT_READ   = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_RANGE    = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

endpackage

// ===== hw/rtl/positional_record_list.sv =====
// Ordered list of up to CAPACITY student records held in one memory.
// Request channel (req_): tuser carries the action (append, insert before a
// 1-based position, delete at a position, find by number, read a position),
// tdata the position and the record. Each request gives exactly one response
// transfer (rsp_): tuser the status, tdata the affected position, the entry
// count after the action and, for a successful find or read, the record.
// One request is worked at a time; req_tready is low from acceptance until
// the response has been taken.
// Append, error cases and a delete of the last entry go straight to the
// response. Read, delete, insert and find first walk the memory, and an
// insert then writes the new record into the gap; a find stops at the
// first match or runs to the end of the list on a miss.
// A shift or search moves one entry a cycle through the single read and
// single write port of the record memory.
// Reset empties the list at once; no clearing pass is needed. While
// rsp_tready is low the response holds and no new request is taken.
module positional_record_list (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // position, name, number, age, score (low to high)
   input  logic [prl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action
   input  logic [prl_pkg::ACTION_W-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // found_position, count_after, name, number, age, score (low to high)
   output logic [prl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [prl_pkg::STATUS_W-1:0]       rsp_tuser
);

   import prl_pkg::*;

   `include "positional_record_list_assert.svh"

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_PUT  = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             issue_ff, issue_in;
   logic             rd_vld_ff;

   // request held while it is worked
   action_type       op_ff, op_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   record_type       key_rec_ff, key_rec_in;
   logic [IDX_W-1:0] walk_addr_ff, walk_addr_in;
   logic [IDX_W-1:0] end_addr_ff, end_addr_in;

   // memory read pipe
   record_type       rd_data_ff;
   logic [IDX_W-1:0] rd_tag_ff;
   logic             rd_last_ff;

   // response register
   status_type       status_ff, status_in;
   logic [POS_W-1:0] where_ff, where_in;
   record_type       out_rec_ff, out_rec_in;

   // memory port
   record_type       mem [CAPACITY];
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   record_type       mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;

   // request fields
   logic [POS_W-1:0] req_pos;
   record_type       req_rec;

   // range helpers
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] req_pos_ext;
   logic [CMP_W-1:0] pos_ff_ext;
   logic [CMP_W-1:0] cnt_p1;
   logic [CMP_W-1:0] cnt_m1;
   logic [CMP_W-1:0] req_pos_m1;
   logic [CMP_W-1:0] pos_ff_m1;
   logic [CMP_W-1:0] tag_p1;
   logic             list_full;
   logic             list_empty;
   logic             pos_ok;

   assign req_pos = req_tdata[POS_W-1:0];
   assign req_rec = record_type'(req_tdata[POS_W +: REC_W]);

   assign cnt_ext     = CMP_W'(count_ff);
   assign req_pos_ext = CMP_W'(req_pos);
   assign pos_ff_ext  = CMP_W'(pos_ff);
   assign cnt_p1      = cnt_ext + CMP_W'(1);
   assign cnt_m1      = cnt_ext - CMP_W'(1);
   assign req_pos_m1  = req_pos_ext - CMP_W'(1);
   assign pos_ff_m1   = pos_ff_ext - CMP_W'(1);
   assign tag_p1      = CMP_W'(rd_tag_ff) + CMP_W'(1);
   assign list_full   = (count_ff == CNT_W'(CAPACITY));
   assign list_empty  = (count_ff == '0);
   assign pos_ok      = (req_pos_ext != '0) && (req_pos_ext <= cnt_ext);

   // handshake
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_rec_ff, cnt_ext[POS_W-1:0], where_ff});

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      key_rec_in   = key_rec_ff;
      walk_addr_in = walk_addr_ff;
      end_addr_in  = end_addr_ff;
      status_in    = status_ff;
      where_in     = where_ff;
      out_rec_in   = out_rec_ff;
      mem_we       = 1'b0;
      mem_waddr    = rd_tag_ff;
      mem_wdata    = rd_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = walk_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = action_type'(req_tuser);
               pos_in     = req_pos;
               key_rec_in = req_rec;
               out_rec_in = '0;
               status_in  = ST_OK;
               where_in   = '0;
               issue_in   = 1'b1;
               state_in   = S_RESP;
               unique case (req_tuser)
                  ACT_APPEND: begin
                     if (list_full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_ext[IDX_W-1:0];
                        mem_wdata = req_rec;
                        count_in  = count_ff + CNT_W'(1);
                        where_in  = cnt_p1[POS_W-1:0];
                     end
                  end
                  ACT_INSERT: begin
                     if (!pos_ok) begin
                        status_in = ST_RANGE;
                     end else if (list_full) begin
                        status_in = ST_FULL;
                     end else begin
                        walk_addr_in = cnt_m1[IDX_W-1:0];
                        end_addr_in  = req_pos_m1[IDX_W-1:0];
                        state_in     = S_WALK;
                     end
                  end
                  ACT_DELETE: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                     end else if (!pos_ok) begin
                        status_in = ST_RANGE;
                     end else if (req_pos_ext == cnt_ext) begin
                        // last entry goes without any shift
                        count_in = count_ff - CNT_W'(1);
                        where_in = req_pos;
                     end else begin
                        walk_addr_in = req_pos_ext[IDX_W-1:0];
                        end_addr_in  = cnt_m1[IDX_W-1:0];
                        state_in     = S_WALK;
                     end
                  end
                  ACT_FIND: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        walk_addr_in = '0;
                        end_addr_in  = cnt_m1[IDX_W-1:0];
                        state_in     = S_WALK;
                     end
                  end
                  ACT_READ: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                     end else if (!pos_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        walk_addr_in = req_pos_m1[IDX_W-1:0];
                        end_addr_in  = req_pos_m1[IDX_W-1:0];
                        state_in     = S_WALK;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end

         S_WALK: begin
            // issue one read a cycle until the end address
            mem_re = issue_ff;
            if (issue_ff) begin
               if (walk_addr_ff == end_addr_ff) begin
                  issue_in = 1'b0;
               end else if (op_ff == ACT_INSERT) begin
                  walk_addr_in = walk_addr_ff - IDX_W'(1);
               end else begin
                  walk_addr_in = walk_addr_ff + IDX_W'(1);
               end
            end
            // use the entry read in the previous cycle
            if (rd_vld_ff) begin
               unique case (op_ff)
                  ACT_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_tag_ff + IDX_W'(1);
                     if (rd_last_ff) begin
                        state_in = S_PUT;
                     end
                  end
                  ACT_DELETE: begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_tag_ff - IDX_W'(1);
                     if (rd_last_ff) begin
                        count_in = count_ff - CNT_W'(1);
                        where_in = pos_ff;
                        state_in = S_RESP;
                     end
                  end
                  ACT_FIND: begin
                     if (rd_data_ff.number == key_rec_ff.number) begin
                        out_rec_in = rd_data_ff;
                        where_in   = tag_p1[POS_W-1:0];
                        issue_in   = 1'b0;
                        state_in   = S_RESP;
                     end else if (rd_last_ff) begin
                        status_in = ST_NOTFOUND;
                        state_in  = S_RESP;
                     end
                  end
                  ACT_READ: begin
                     out_rec_in = rd_data_ff;
                     where_in   = pos_ff;
                     state_in   = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_PUT: begin
            // new record into the gap left by the shift
            mem_we    = 1'b1;
            mem_waddr = pos_ff_m1[IDX_W-1:0];
            mem_wdata = key_rec_ff;
            count_in  = count_ff + CNT_W'(1);
            where_in  = pos_ff;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= mem_re;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      key_rec_ff   <= key_rec_in;
      walk_addr_ff <= walk_addr_in;
      end_addr_ff  <= end_addr_in;
      status_ff    <= status_in;
      where_ff     <= where_in;
      out_rec_ff   <= out_rec_in;
      rd_tag_ff    <= mem_raddr;
      rd_last_ff   <= (mem_raddr == end_addr_ff);
   end

   // record memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // checks
   `PRL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `PRL_ASSERT_ALWAYS(a_one_side, clock, reset, !(req_tready && rsp_tvalid), "ready while response pending")
   `PRL_ASSERT_ALWAYS(a_no_write_resp, clock, reset, !(mem_we && state_ff == S_RESP), "memory write during response")
   `PRL_ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && status_ff != ST_OK, out_rec_ff == '0 && where_ff == '0, "error response carries data")
   `PRL_ASSERT_NEXT(a_stall_count, clock, reset, rsp_tvalid && !rsp_tready, $stable(count_ff), "count moved during stall")

endmodule

// ===== tb/tb_positional_record_list.sv =====
`timescale 1ns / 1ps

module tb_positional_record_list;
   import prl_pkg::*;

   localparam int LIMIT_CYCLES     = 2_000_000;
   localparam int RANDOM_ITEMS     = 1700;
   localparam int FILL_ITEMS       = 200;
   localparam int POOL_SIZE        = 16;
   localparam int LONG_HOLD_ITEM   = 600;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 200;

   // action codes the block does not define
   localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

   // segment kinds of the random stimulus
   typedef enum int {SEG_GROW, SEG_SHRINK, SEG_MIXED} segment_type;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [POS_W-1:0]    position;
      record_type          rec;
      bit                  drain_first;
   } list_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    found_position;
      logic [POS_W-1:0]    count_after;
      record_type          rec;
   } list_result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata  = '0;
   logic [ACTION_W-1:0]       req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]       rsp_tuser;

   list_request_type pending_requests[$];
   list_result_type  expected_responses[$];
   list_request_type current_request;

   // predictor copy of the list
   record_type stored_records [CAPACITY];
   int         stored_count = 0;

   // generation-side tracking of the entry count, to aim positions
   int est_count = 0;
   int total_items = 0;
   logic [NUMBER_W-1:0] number_pool [POOL_SIZE];

   int accepted_total = 0;
   int checked_total  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   positional_record_list uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // apply one action to the predictor list and return the response it gives
   function automatic list_result_type apply_list_action(list_request_type req);
      list_result_type res;
      int pos;
      int i;
      res = '{status: ST_OK, found_position: '0, count_after: '0, rec: '0};
      pos = req.position;
      case (req.action)
         ACT_APPEND: begin
            if (stored_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               stored_records[stored_count] = req.rec;
               stored_count++;
               res.found_position = POS_W'(stored_count);
            end
         end
         ACT_INSERT: begin
            if (pos == 0 || pos > stored_count) begin
               res.status = ST_RANGE;
            end else if (stored_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = stored_count; i >= pos; i--)
                  stored_records[i] = stored_records[i-1];
               stored_records[pos-1] = req.rec;
               stored_count++;
               res.found_position = POS_W'(pos);
            end
         end
         ACT_DELETE: begin
            if (stored_count == 0) begin
               res.status = ST_EMPTY;
            end else if (pos == 0 || pos > stored_count) begin
               res.status = ST_RANGE;
            end else begin
               for (i = pos - 1; i + 1 < stored_count; i++)
                  stored_records[i] = stored_records[i+1];
               stored_count--;
               res.found_position = POS_W'(pos);
            end
         end
         ACT_FIND: begin
            if (stored_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_NOTFOUND;
               for (i = 0; i < stored_count; i++) begin
                  if (stored_records[i].number == req.rec.number) begin
                     res.status = ST_OK;
                     res.found_position = POS_W'(i + 1);
                     res.rec = stored_records[i];
                     break;
                  end
               end
            end
         end
         ACT_READ: begin
            if (stored_count == 0) begin
               res.status = ST_EMPTY;
            end else if (pos == 0 || pos > stored_count) begin
               res.status = ST_RANGE;
            end else begin
               res.found_position = POS_W'(pos);
               res.rec = stored_records[pos-1];
            end
         end
         default: res.status = ST_RANGE;
      endcase
      res.count_after = POS_W'(stored_count);
      return res;
   endfunction

   // record with random content, number mostly from a small pool so finds hit
   function automatic record_type random_record();
      record_type r;
      r.name   = {$urandom, $urandom};
      r.number = ($urandom_range(0, 4) == 0) ? NUMBER_W'({$urandom, $urandom})
                                            : number_pool[$urandom_range(0, POOL_SIZE - 1)];
      r.age    = AGE_W'($urandom_range(0, 255));
      r.score  = {$urandom, $urandom};
      return r;
   endfunction

   // mostly in range, sometimes zero, one past the end or anything
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      int p;
      r = $urandom_range(0, 19);
      if (r < 17)
         p = $urandom_range(1, (est_count > 0) ? est_count : 1);
      else if (r == 17)
         p = 0;
      else if (r == 18)
         p = est_count + 1;
      else
         p = $urandom_range(0, 255);
      return POS_W'(p);
   endfunction

   // queue one request and track the count it leads to
   task automatic queue_request(input logic [ACTION_W-1:0] action,
                                input logic [POS_W-1:0] position,
                                input record_type rec, input bit drain_first);
      list_request_type item;
      int pos;
      item.action      = action;
      item.position    = position;
      item.rec         = rec;
      item.drain_first = drain_first;
      pending_requests.push_back(item);
      total_items++;
      pos = position;
      case (action)
         ACT_APPEND: if (est_count < CAPACITY) est_count++;
         ACT_INSERT: if (pos >= 1 && pos <= est_count && est_count < CAPACITY) est_count++;
         ACT_DELETE: if (pos >= 1 && pos <= est_count) est_count--;
         default: ;
      endcase
   endtask

   // stimulus, then end of run
   initial begin : stimulus
      record_type  zero_rec;
      record_type  ones_rec;
      record_type  rec;
      segment_type seg;
      int          seg_left;
      int          r;
      logic [ACTION_W-1:0] act;

      for (int k = 0; k < POOL_SIZE; k++)
         number_pool[k] = NUMBER_W'({$urandom, $urandom});
      number_pool[0] = '1;
      zero_rec = '0;
      ones_rec = '1;

      // empty list cases and unknown actions
      queue_request(ACT_READ, 8'd1, random_record(), 1'b0);
      queue_request(ACT_DELETE, 8'd1, random_record(), 1'b0);
      queue_request(ACT_FIND, 8'd0, random_record(), 1'b0);
      queue_request(ACT_INSERT, 8'd1, random_record(), 1'b0);
      for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
         queue_request(ACTION_W'(a), 8'd1, ones_rec, 1'b0);
      // field extremes
      queue_request(ACT_APPEND, 8'd255, zero_rec, 1'b0);
      queue_request(ACT_APPEND, 8'd0, ones_rec, 1'b0);
      queue_request(ACT_READ, 8'd0, zero_rec, 1'b0);
      queue_request(ACT_READ, 8'd3, zero_rec, 1'b0);
      queue_request(ACT_READ, 8'd255, zero_rec, 1'b0);
      queue_request(ACT_READ, 8'd1, zero_rec, 1'b0);
      queue_request(ACT_READ, 8'd2, zero_rec, 1'b0);
      // inserts at the front, before the last entry and one past the end
      rec = random_record();
      rec.number = '1;
      queue_request(ACT_INSERT, 8'd1, rec, 1'b0);
      queue_request(ACT_INSERT, 8'd3, random_record(), 1'b0);
      queue_request(ACT_INSERT, 8'd5, random_record(), 1'b0);
      // first of duplicate numbers, a miss and a zero key
      queue_request(ACT_FIND, 8'd0, ones_rec, 1'b0);
      rec = zero_rec;
      rec.number = 56'h12_3456_789a_bcde;
      queue_request(ACT_FIND, 8'd0, rec, 1'b0);
      queue_request(ACT_FIND, 8'd0, zero_rec, 1'b0);
      // deletes out of range, at the front and one past the end
      queue_request(ACT_DELETE, 8'd0, zero_rec, 1'b0);
      queue_request(ACT_DELETE, 8'd6, zero_rec, 1'b0);
      queue_request(ACT_DELETE, 8'd1, zero_rec, 1'b0);
      queue_request(ACT_DELETE, 8'd4, zero_rec, 1'b0);

      // random segments, the first one filling the list up
      seg = SEG_GROW;
      seg_left = FILL_ITEMS;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            r = $urandom_range(0, 2);
            seg = (r == 0) ? SEG_GROW : (r == 1) ? SEG_SHRINK : SEG_MIXED;
            seg_left = $urandom_range(40, 250);
         end
         seg_left--;
         r = $urandom_range(0, 99);
         case (seg)
            SEG_GROW:
               act = (r < 50) ? ACT_APPEND : (r < 85) ? ACT_INSERT : (r < 90) ? ACT_FIND :
                     (r < 95) ? ACT_READ : (r < 99) ? ACT_DELETE : ACT_UNUSED_FIRST;
            SEG_SHRINK:
               act = (r < 15) ? ACT_APPEND : (r < 25) ? ACT_INSERT : (r < 75) ? ACT_DELETE :
                     (r < 85) ? ACT_FIND : (r < 97) ? ACT_READ : ACT_UNUSED_FIRST;
            default:
               act = (r < 22) ? ACT_APPEND : (r < 44) ? ACT_INSERT : (r < 66) ? ACT_DELETE :
                     (r < 82) ? ACT_FIND : (r < 97) ? ACT_READ : ACT_UNUSED_FIRST;
         endcase
         if (act == ACT_UNUSED_FIRST)
            act = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
         queue_request(act, (act == ACT_APPEND) ? POS_W'($urandom_range(0, 255)) : pick_position(),
                       random_record(), (n == 0) || (n == RANDOM_ITEMS / 2));
      end

      wait (!reset);
      wait (accepted_total == total_items);
      wait (checked_total == accepted_total);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("tb_positional_record_list: done, clean");
      else
         $display("tb_positional_record_list: done, errors");
      $finish;
   end

   // hold reset at the start, then release it
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver: bursts with gaps, optional pause until drained
   always @(posedge clock) begin : request_driver
      static int burst_left = 0;
      static int gap_left = 0;
      int accepted_now;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         accepted_now = accepted_total;
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(apply_list_action(current_request));
            accepted_now++;
            accepted_total <= accepted_now;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && accepted_now != checked_total)) begin
               current_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= current_request.action;
               req_tdata  <= {current_request.rec, current_request.position};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready: changing duty, plus one long hold-off
   always @(posedge clock) begin : response_ready
      static bit hold_done = 1'b0;
      static int hold_left = 0;
      static int mode_left = 0;
      static int ready_pct = 100;
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && accepted_total >= LONG_HOLD_ITEM) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(50, 400);
            r = $urandom_range(0, 2);
            ready_pct = (r == 0) ? 100 : (r == 1) ? 70 : 25;
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin : response_check
      list_result_type want;
      record_type      got_rec;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_total <= checked_total + 1;
         got_rec = rsp_tdata[2*POS_W +: REC_W];
         if (expected_responses.size() == 0) begin
            $error("response transfer with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[POS_W-1:0] !== want.found_position) begin
               $error("found_position: expected %0d, got %0d", want.found_position,
                      rsp_tdata[POS_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[2*POS_W-1:POS_W] !== want.count_after) begin
               $error("count_after: expected %0d, got %0d", want.count_after,
                      rsp_tdata[2*POS_W-1:POS_W]);
               mismatch_count++;
            end
            if (got_rec.name !== want.rec.name) begin
               $error("out_name: expected %h, got %h", want.rec.name, got_rec.name);
               mismatch_count++;
            end
            if (got_rec.number !== want.rec.number) begin
               $error("out_number: expected %h, got %h", want.rec.number, got_rec.number);
               mismatch_count++;
            end
            if (got_rec.age !== want.rec.age) begin
               $error("out_age: expected %0d, got %0d", want.rec.age, got_rec.age);
               mismatch_count++;
            end
            if (got_rec.score !== want.rec.score) begin
               $error("out_score: expected %h, got %h", want.rec.score, got_rec.score);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb_positional_record_list: done, errors");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/prl_pkg.sv
hw/rtl/positional_record_list.sv
tb/tb_positional_record_list.sv
